// ----- rtl/multi_led_rgb_fader_defines.svh -----
// Assertion macros shared by the RGB fader RTL.
`ifndef MULTI_LED_RGB_FADER_DEFINES_SVH
`define MULTI_LED_RGB_FADER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define MLRF_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define MLRF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/mlrf_pkg.sv -----
// Types and constants of the RGB LED fader.
package mlrf_pkg;

	localparam int RESULT_LIMIT = 16;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_BITS     = 24;
	localparam int DIV_CNT_W    = $clog2(DIV_BITS);

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic REG_LED_COUNT   = 1'b0;
	localparam logic REG_TICK_MILLIS = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  led_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] fade_time;
	} request_t;

	typedef struct packed {
		logic [3:0] led_number;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       fade_done;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// One classified command, handed from front to back.
	typedef struct packed {
		logic        tick;
		logic [3:0]  lo;
		logic [4:0]  hi;
		color_t      color;
		logic [15:0] step;
	} job_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_PUSH
	} front_state_t;

endpackage

// ----- rtl/mlrf_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct.
interface mlrf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/multi_led_rgb_fader.sv -----
// Top level of the RGB LED cross-fader.
//
// Keeps up to 16 RGB LEDs (MAX_LEDS, capped at 16) and fades each from its
// start color toward a target. A set request (cmd 0) gives one LED, or all
// LEDs in use when led_index is 0, a new target and a fade time; the step is
// 65535 * tick_millis / fade_time, saturated to 16 bits, with a fade time
// of 0 taken as 1. An index at or past the count in use is dropped. A tick
// request (cmd 1) walks LEDs 0 .. count-1 and returns one result each, the
// final one flagged by last; a set returns nothing. The front end takes a
// request only while idle; a set then runs the 24-step bit-serial divider
// and pushes its command, and no new request is taken while a command is
// being divided or pushed (the push waits while the queue is full).
// The walker picks up a command when idle, then writes one addressed LED
// per cycle for a set, or takes two phases per LED for a tick (multiply,
// then blend and write back), the write back waiting on any output stall.
// A two-entry command queue lets the front end take and divide the next
// request while the walker is still busy, and the result register lets the
// walker form the next LED's products while a result waits.
// Registers: index 0 led_count (5 bits, reset 16), index 1 tick_millis
// (8 bits, reset 1); write them only while the block is idle. All LED state
// clears at reset; there is no clearing pass.
module multi_led_rgb_fader
	import mlrf_pkg::*;
#(
	parameter int MAX_LEDS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [0:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	mlrf_stream_if.sink   request,
	mlrf_stream_if.source result
);

	// Only the first 16 entries can ever be addressed or reported.
	localparam int DEPTH = (MAX_LEDS < RESULT_LIMIT) ? MAX_LEDS : RESULT_LIMIT;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [4:0] led_count_q;
	logic [7:0] tick_millis_q;

	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t job;
	job_t head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q   <= 5'd16;
			tick_millis_q <= 8'd1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LED_COUNT:   led_count_q   <= cfg_data[4:0];
				REG_TICK_MILLIS: tick_millis_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: classify the request, divide out the step, queue a command.
	mlrf_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.led_count  (led_count_q),
		.tick_millis(tick_millis_q),
		.request    (request),
		.push       (push),
		.job        (job),
		.full       (full)
	);

	// Command queue between the two halves.
	mlrf_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.job   (job),
		.pop   (pop),
		.head  (head),
		.full  (full),
		.empty (empty)
	);

	// Back end: walks the LED table and drives the result channel.
	mlrf_back #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

endmodule

// ----- rtl/mlrf_front.sv -----
// Front end: accepts requests, classifies them and divides out the fade step.
module mlrf_front
	import mlrf_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [4:0]           led_count,
	input  logic [7:0]           tick_millis,
	mlrf_stream_if.sink          request,
	output logic                 push,
	output job_t                 job,
	input  logic                 full
);

	localparam logic [4:0] CNT_MAX = 5'(DEPTH);

	front_state_t state_q, state_d;

	job_t                 job_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [16:0]          rem_q;
	logic [15:0]          div_q;
	logic [DIV_CNT_W-1:0] bit_q;

	logic [4:0]  cnt;
	logic        accept;
	logic        is_tick;
	logic        is_all;
	logic        set_ok;
	logic [16:0] trial;
	logic        trial_ge;

	assign cnt     = (led_count > CNT_MAX) ? CNT_MAX : led_count;
	assign is_tick = (request.payload.cmd == CMD_TICK);
	assign is_all  = (request.payload.led_index == 8'd0);
	// Covers the broadcast case too: index 0 is in range whenever count is nonzero.
	assign set_ok  = ({3'b000, cnt} > request.payload.led_index);

	assign trial    = {rem_q[15:0], quo_q[DIV_BITS-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		request.ready = (state_q == FS_IDLE);
		accept        = request.valid && (state_q == FS_IDLE);
		push          = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					if (is_tick) begin
						state_d = (cnt != 5'd0) ? FS_PUSH : FS_IDLE;
					end else if (set_ok) begin
						state_d = FS_DIV;
					end
				end
			end
			FS_DIV: begin
				if (bit_q == DIV_CNT_W'(DIV_BITS - 1)) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// Restoring divider, one quotient bit per cycle: (65535 * tick_millis) / fade.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (accept) begin
			bit_q <= '0;
		end else if (state_q == FS_DIV) begin
			bit_q <= bit_q + DIV_CNT_W'(1);
		end
	end

	// A tick always walks from entry 0; its index field is ignored.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.tick  <= is_tick;
			job_q.lo    <= (is_all || is_tick) ? 4'd0 : request.payload.led_index[3:0];
			job_q.hi    <= (is_all || is_tick) ? cnt
			               : request.payload.led_index[4:0] + 5'd1;
			job_q.color <= {request.payload.red, request.payload.green,
			                request.payload.blue};
			job_q.step  <= '0;
			quo_q       <= {tick_millis, 16'h0000} - {16'h0000, tick_millis};
			rem_q       <= '0;
			div_q       <= (request.payload.fade_time == 16'd0) ? 16'd1
			               : request.payload.fade_time;
		end else if (state_q == FS_DIV) begin
			rem_q <= trial_ge ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[DIV_BITS-2:0], trial_ge};
		end
	end

	always_comb begin
		job = job_q;
		if (!job_q.tick) begin
			job.step = (quo_q[DIV_BITS-1:16] != '0) ? 16'hFFFF : quo_q[15:0];
		end
	end

endmodule

// ----- rtl/mlrf_queue.sv -----
// Two-entry command queue between front end and LED walker.
`include "multi_led_rgb_fader_defines.svh"
module mlrf_queue
	import mlrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job;
		end
	end

	`MLRF_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
	`MLRF_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from an empty queue")
	`MLRF_ASSERT_NOW(a_fill_bound, 1'b1, cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH), "fill count too big")

endmodule

// ----- rtl/mlrf_back.sv -----
// LED walker: applies set commands and blends each LED on a tick.
`include "multi_led_rgb_fader_defines.svh"
module mlrf_back
	import mlrf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        empty,
	output logic        pop,
	mlrf_stream_if.source result
);

	color_t      cur_q   [DEPTH];
	color_t      start_q [DEPTH];
	color_t      tgt_q   [DEPTH];
	logic [15:0] pos_q   [DEPTH];
	logic [15:0] step_q  [DEPTH];

	logic       busy_q;
	logic       phase_q;
	logic [3:0] ptr_q;

	logic [7:0] amt_s1;
	color_t     mix_cur_s1;
	color_t     mix_tgt_s1;

	logic       res_valid_q;
	result_t    res_q;

	logic [IDX_W-1:0] e;
	logic             last_entry;
	logic             out_free;
	logic             set_wr;
	logic             blend_s0;
	logic             load;
	logic [7:0]       amt;
	logic [7:0]       inv;
	logic             done;
	color_t           new_color;
	logic [16:0]      pos_sum;
	logic [15:0]      pos_next;

	function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] f);
		logic [15:0] p;
		p = 16'(v) * 16'(f);
		return p[15:8];
	endfunction

	assign e          = ptr_q[IDX_W-1:0];
	assign last_entry = (({1'b0, ptr_q} + 5'd1) == head.hi);
	assign out_free   = !res_valid_q || result.ready;
	assign set_wr     = busy_q && !head.tick;
	assign blend_s0   = busy_q && head.tick && !phase_q;
	assign load       = busy_q && head.tick && phase_q && out_free;
	assign pop        = (set_wr || load) && last_entry;

	// Phase 0: read entry and form the two partial products per channel.
	assign amt = pos_q[e][15:8];
	assign inv = 8'(9'd256 - {1'b0, amt});

	always_ff @(posedge clk) begin
		if (blend_s0) begin
			amt_s1           <= amt;
			mix_cur_s1.red   <= scale8(cur_q[e].red, inv);
			mix_cur_s1.green <= scale8(cur_q[e].green, inv);
			mix_cur_s1.blue  <= scale8(cur_q[e].blue, inv);
			mix_tgt_s1.red   <= scale8(tgt_q[e].red, amt);
			mix_tgt_s1.green <= scale8(tgt_q[e].green, amt);
			mix_tgt_s1.blue  <= scale8(tgt_q[e].blue, amt);
		end
	end

	// Phase 1: pick start, target or blended color; advance position.
	always_comb begin
		done = (amt_s1 == 8'hFF);
		if (amt_s1 == 8'h00) begin
			new_color = start_q[e];
		end else if (done) begin
			new_color = tgt_q[e];
		end else begin
			new_color.red   = mix_cur_s1.red + mix_tgt_s1.red;
			new_color.green = mix_cur_s1.green + mix_tgt_s1.green;
			new_color.blue  = mix_cur_s1.blue + mix_tgt_s1.blue;
		end
		pos_sum  = {1'b0, pos_q[e]} + {1'b0, step_q[e]};
		pos_next = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				cur_q[i]   <= '0;
				start_q[i] <= '0;
				tgt_q[i]   <= '0;
				pos_q[i]   <= '0;
				step_q[i]  <= '0;
			end
		end else if (set_wr) begin
			start_q[e] <= cur_q[e];
			tgt_q[e]   <= head.color;
			pos_q[e]   <= '0;
			step_q[e]  <= head.step;
		end else if (load) begin
			cur_q[e] <= new_color;
			if (!done) begin
				pos_q[e] <= pos_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			ptr_q   <= '0;
		end else if (!busy_q) begin
			if (!empty) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				ptr_q   <= head.lo;
			end
		end else if (set_wr || load) begin
			phase_q <= 1'b0;
			if (last_entry) begin
				busy_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q + 4'd1;
			end
		end else if (blend_s0) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.led_number <= ptr_q;
			res_q.out_red    <= new_color.red;
			res_q.out_green  <= new_color.green;
			res_q.out_blue   <= new_color.blue;
			res_q.fade_done  <= done;
			res_q.last       <= last_entry;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	`MLRF_ASSERT_NOW(a_busy_has_job, busy_q, !empty, "walker busy with no queued command")
	`MLRF_ASSERT_NOW(a_ptr_in_span, busy_q, ({1'b0, ptr_q} < head.hi), "LED pointer past span")
	`MLRF_ASSERT_NEXT(a_last_ends_walk, load && last_entry, !busy_q, "walk still busy after last")

endmodule

// ----- verif/tb_multi_led_rgb_fader.sv -----
// Testbench for the RGB LED cross-fader: directed and random requests checked against a local model.
module tb_multi_led_rgb_fader
	import mlrf_pkg::*;
();

	localparam int LED_SLOTS    = 16;
	localparam int DRAIN_CYCLES = 100;      // a set plus a 16-LED tick stays well under this
	localparam int LONG_HOLD    = 400;      // receiver stall, long enough to back up the queue
	localparam int RUN_LIMIT    = 5000000;  // time units, several times the slowest legal run

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wen;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	mlrf_stream_if #(.payload_t(request_t)) req_if ();
	mlrf_stream_if #(.payload_t(result_t))  res_if ();

	multi_led_rgb_fader #(.MAX_LEDS(LED_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (req_if),
		.result    (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Fader model: own copy of the registers and the LED table
	// ------------------------------------------------------------------
	logic [4:0]  led_count_reg;
	logic [7:0]  tick_ms_reg;
	color_t      cur_color [LED_SLOTS];
	color_t      from_color[LED_SLOTS];
	color_t      dest_color[LED_SLOTS];
	logic [15:0] fade_pos  [LED_SLOTS];
	logic [15:0] fade_inc  [LED_SLOTS];

	request_t cmd_backlog[$];   // requests waiting for the driver
	result_t  colors_due[$];    // LED colors the block still owes us
	int       errors = 0;

	function automatic void fader_reset();
		for (int i = 0; i < LED_SLOTS; i++) begin
			cur_color[i]  = '0;
			from_color[i] = '0;
			dest_color[i] = '0;
			fade_pos[i]   = '0;
			fade_inc[i]   = '0;
		end
		led_count_reg = 5'd16;
		tick_ms_reg   = 8'd1;
	endfunction

	// Count register clamped to the table size and to one tick's result budget.
	function automatic int leds_in_use();
		int n = led_count_reg;
		if (n > LED_SLOTS) n = LED_SLOTS;
		if (n > RESULT_LIMIT) n = RESULT_LIMIT;
		return n;
	endfunction

	// 65535 * tick / fade, zero fade taken as one, saturated to 16 bits.
	function automatic logic [15:0] fade_increment(logic [15:0] fade_ms);
		int unsigned divisor;
		int unsigned quotient;
		divisor  = (fade_ms == 16'd0) ? 1 : fade_ms;
		quotient = (32'd65535 * tick_ms_reg) / divisor;
		if (quotient > 65535) quotient = 65535;
		return quotient[15:0];
	endfunction

	function automatic logic [7:0] scale8(logic [7:0] v, int unsigned f);
		int unsigned p;
		p = v * f;
		return p[15:8];
	endfunction

	function automatic color_t mix_color(color_t c, color_t t, int unsigned a);
		color_t m;
		m.red   = scale8(c.red,   256 - a) + scale8(t.red,   a);
		m.green = scale8(c.green, 256 - a) + scale8(t.green, a);
		m.blue  = scale8(c.blue,  256 - a) + scale8(t.blue,  a);
		return m;
	endfunction

	// Apply one accepted request to the model; a tick queues one color per LED.
	function automatic void fader_apply(request_t rq);
		int          cnt;
		int          lo;
		int          hi;
		int unsigned amount;
		logic [15:0] inc;
		logic [16:0] pos;
		logic        done;
		result_t     r;
		cnt = leds_in_use();
		if (rq.cmd == CMD_SET) begin
			inc = fade_increment(rq.fade_time);
			if (rq.led_index == 8'd0) begin
				lo = 0;
				hi = cnt;
			end else if (rq.led_index < cnt) begin
				lo = rq.led_index;
				hi = lo + 1;
			end else begin
				return;
			end
			for (int i = lo; i < hi; i++) begin
				fade_pos[i]   = '0;
				fade_inc[i]   = inc;
				from_color[i] = cur_color[i];
				dest_color[i] = '{red: rq.red, green: rq.green, blue: rq.blue};
			end
			return;
		end
		for (int i = 0; i < cnt; i++) begin
			amount = fade_pos[i][15:8];
			done   = (amount == 255);
			if (amount == 0) begin
				cur_color[i] = from_color[i];
			end else if (done) begin
				cur_color[i] = dest_color[i];
			end else begin
				cur_color[i] = mix_color(cur_color[i], dest_color[i], amount);
			end
			// position saturates instead of wrapping; frozen once at target
			if (!done) begin
				pos         = fade_pos[i] + fade_inc[i];
				fade_pos[i] = pos[16] ? 16'hFFFF : pos[15:0];
			end
			r.led_number = 4'(i);
			r.out_red    = cur_color[i].red;
			r.out_green  = cur_color[i].green;
			r.out_blue   = cur_color[i].blue;
			r.fade_done  = done;
			r.last       = (i + 1 == cnt);
			colors_due.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_color(result_t got);
		result_t want;
		if (colors_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = colors_due.pop_front();
		field_check("led_number", want.led_number, got.led_number);
		field_check("out_red",    want.out_red,    got.out_red);
		field_check("out_green",  want.out_green,  got.out_green);
		field_check("out_blue",   want.out_blue,   got.out_blue);
		field_check("fade_done",  want.fade_done,  got.fade_done);
		field_check("last",       want.last,       got.last);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers requests from the backlog, random gap before each
	// ------------------------------------------------------------------
	int tx_gap   = 0;
	bit tx_burst = 1'b0;

	always @(posedge clk) begin
		bit holding;
		if (arst_n) begin
			holding = req_if.valid;
			if (req_if.valid && req_if.ready) begin
				fader_apply(req_if.payload);
				holding = 1'b0;
				if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
			end
			// a held request keeps valid and payload untouched
			if (!holding) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_if.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					req_if.payload <= cmd_backlog.pop_front();
					req_if.valid   <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each color, then draws how long to hold off
	// ------------------------------------------------------------------
	int rx_gap      = 0;
	int rx_hold     = 0;
	int rx_hold_req = 0;   // set by the stimulus to ask for a long stall
	bit rx_burst    = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				check_color(res_if.payload);
				if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
				rx_gap = rx_burst ? 0 : $urandom_range(0, 10);
			end
			if (rx_hold_req > 0) begin
				rx_hold     = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				res_if.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic request_t set_req(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [15:0] fade);
		request_t rq;
		rq.cmd       = CMD_SET;
		rq.led_index = idx;
		rq.red       = r;
		rq.green     = g;
		rq.blue      = b;
		rq.fade_time = fade;
		return rq;
	endfunction

	// Tick with junk in the unused fields.
	function automatic request_t tick_req();
		request_t rq;
		rq     = set_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom));
		rq.cmd = CMD_TICK;
		return rq;
	endfunction

	// Mostly fades that finish within a dozen ticks, some over the full range.
	function automatic logic [15:0] rand_fade();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			default: return 16'(tick_ms_reg * $urandom_range(0, 12));
		endcase
	endfunction

	// Scenes of a set followed by ticks, runs of ticks, and dropped sets as noise.
	// Dropped sets do not count toward the quota.
	task automatic gen_traffic(int quota);
		int made = 0;
		int cnt;
		int pick;
		int runs;
		logic [7:0] idx;
		while (made < quota) begin
			cnt  = leds_in_use();
			pick = $urandom_range(0, 9);
			if (pick == 7) begin
				cmd_backlog.push_back(set_req(8'($urandom_range(cnt, 255)), 8'($urandom),
					8'($urandom), 8'($urandom), rand_fade()));
			end else if (pick >= 8) begin
				runs = $urandom_range(3, 14);
				repeat (runs) cmd_backlog.push_back(tick_req());
				made += runs;
			end else begin
				idx = (cnt < 2 || $urandom_range(0, 3) == 0) ? 8'd0
					: 8'($urandom_range(1, cnt - 1));
				cmd_backlog.push_back(set_req(idx, 8'($urandom), 8'($urandom), 8'($urandom),
					rand_fade()));
				runs = $urandom_range(1, 4);
				repeat (runs) cmd_backlog.push_back(tick_req());
				made += runs + 1;
			end
		end
	endtask

	// Wait for every request taken and every color back, then let the block go quiet.
	task automatic settle();
		while (cmd_backlog.size() != 0 || req_if.valid || colors_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_LED_COUNT) begin
			led_count_reg = val[4:0];
		end else begin
			tick_ms_reg = val;
		end
	endtask

	task automatic configure(int count, int tick_ms);
		settle();
		write_reg(REG_LED_COUNT, 8'(count));
		write_reg(REG_TICK_MILLIS, 8'(tick_ms));
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		res_if.ready   = 1'b0;
		fader_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values (16 LEDs, 1 ms tick)
		cmd_backlog.push_back(tick_req());                          // all black, nothing moving
		cmd_backlog.push_back(set_req(8'd0, 8'hFF, 8'hFF, 8'hFF, 16'd0)); // zero fade time
		cmd_backlog.push_back(tick_req());                          // shows start, position jumps
		cmd_backlog.push_back(tick_req());                          // at target, done
		cmd_backlog.push_back(tick_req());                          // stays done
		cmd_backlog.push_back(set_req(8'd15, 8'h00, 8'h80, 8'hFF, 16'hFFFF)); // last LED, slowest
		cmd_backlog.push_back(set_req(8'd16, 8'h12, 8'h34, 8'h56, 16'd5));   // index == count
		cmd_backlog.push_back(set_req(8'd255, 8'h12, 8'h34, 8'h56, 16'd5));  // far out of range
		cmd_backlog.push_back(set_req(8'd1, 8'hAA, 8'h55, 8'h0F, 16'd2));    // half-way steps
		repeat (4) cmd_backlog.push_back(tick_req());               // start, blend, done, done
		cmd_backlog.push_back(set_req(8'd0, 8'h5A, 8'hA5, 8'hC3, 16'd3));
		repeat (3) cmd_backlog.push_back(tick_req());

		// Directed, one LED and the longest tick: step saturates
		configure(1, 255);
		cmd_backlog.push_back(set_req(8'd0, 8'h01, 8'hFE, 8'h7F, 16'd1));
		cmd_backlog.push_back(set_req(8'd1, 8'h33, 8'h33, 8'h33, 16'd1));    // beyond count of 1
		repeat (3) cmd_backlog.push_back(tick_req());

		// Random phases across register settings, extremes first
		configure(16, 255);
		gen_traffic(70);
		configure(1, 1);
		gen_traffic(60);
		configure(16, 1);
		gen_traffic(40);

		// long receiver stall while the sender keeps offering
		@(negedge clk) rx_hold_req = LONG_HOLD;
		gen_traffic(40);

		// sender pause until every color is back
		settle();
		gen_traffic(40);

		repeat (3) begin
			configure($urandom_range(1, 16), $urandom_range(1, 255));
			gen_traffic(50);
		end
		configure(16, $urandom_range(2, 254));
		gen_traffic(40);

		settle();
		if (errors == 0) begin
			$display("tb_multi_led_rgb_fader passed");
		end else begin
			$display("tb_multi_led_rgb_fader failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#RUN_LIMIT;
		$display("tb_multi_led_rgb_fader failed");
		$finish;
	end

endmodule
